### sv/assert_macros.svh
// Assertion helper macros shared by the packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Plain invariant checked every clock outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`endif

### sv/grp_pkg.sv
// ----------------------------------------------------------------------------
// grp_pkg
// Shared constants for the guillotine rectangle packer.
// ----------------------------------------------------------------------------
`default_nettype none
package grp_pkg;
   localparam int DIM_BITS   = 13;
   localparam int AREA_BITS  = 25;
   localparam int COORD_BITS = 12;
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic FUNC_PLACE = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;
   localparam logic CSR_BIN_W = 1'b0;
   localparam logic CSR_BIN_H = 1'b1;
endpackage
`default_nettype wire

### sv/guillotine_rect_packer.sv
// ----------------------------------------------------------------------------
// guillotine_rect_packer
// First-fit guillotine bin packer over a free list kept in one memory.
// ----------------------------------------------------------------------------
// One request word at a time. A placement scans the free list from entry
// 0, one memory read per cycle, until the first fit, then shifts the tail
// up one slot, one entry at a time (read then write), and writes the two
// remainders. The result word is held in an output register until taken,
// and no request word is taken while it waits. Reset loads entry 0 with
// the whole bin. No clearing pass: entries past the count are unread.
`default_nettype none
`include "assert_macros.svh"
module guillotine_rect_packer #(
   parameter int MAX_FREE   = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tuser,  // [0] func
   input  wire logic [31:0] req_tdata,  // [12:0] rect_width, [25:13] rect_height
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,  // status, pos_x, pos_y, filled_area
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [12:0] csr_data
);
   localparam int DB = grp_pkg::DIM_BITS;
   localparam int AB = grp_pkg::AREA_BITS;
   localparam int CB = grp_pkg::COORD_BITS;
   localparam int IB = $clog2(MAX_FREE);
   localparam int NB = IB + 1;
   localparam int EB = 2 * CB + 2 * DB;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_SHRD  = 7'b0000100,
      S_SHWR  = 7'b0001000,
      S_WRA   = 7'b0010000,
      S_WRB   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      logic [DB-1:0] w;
      logic [DB-1:0] h;
   } rect_type;

   rect_type mem [MAX_FREE];
   rect_type rd_data_ff, wr_data;
   logic [IB-1:0] rd_addr, wr_addr;
   logic wr_en;

   state_type state_ff, state_in;
   logic [NB-1:0] count_ff, count_in, idx_ff, idx_in, found_ff, found_in;
   logic [AB-1:0] area_ff, area_in;
   logic [DB-1:0] binw_ff, binh_ff, rw_ff, rh_ff, rw_in, rh_in;
   rect_type c_ff, c_in, a_ff, a_in, b_ff, b_in;
   logic rvalid_ff, rvalid_in;
   logic [1:0] st_ff, st_in;
   logic [CB-1:0] px_ff, px_in, py_ff, py_in;
   logic rsp_full_ff, rsp_full_in;
   logic [DB-1:0] dw, dh, cw, ch;
   logic fit;
   localparam logic [DB-1:0] BIN_MAX = DB'(1) << CB;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign req_tready = (state_ff == S_IDLE) && !rsp_full_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_full_ff;
   assign rsp_tdata  = {5'd0, area_ff, py_ff, px_ff, st_ff} & 56'hFFFFFFFFFFFFFF;
   assign fit = rw_ff <= rd_data_ff.w && rh_ff <= rd_data_ff.h;
   assign dw = c_ff.w - rw_ff;
   assign dh = c_ff.h - rh_ff;
   assign cw = (binw_ff > BIN_MAX) ? BIN_MAX : binw_ff;
   assign ch = (binh_ff > BIN_MAX) ? BIN_MAX : binh_ff;

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; found_in = found_ff;
      area_in = area_ff; rw_in = rw_ff; rh_in = rh_ff; c_in = c_ff;
      a_in = a_ff; b_in = b_ff; rvalid_in = 1'b0; st_in = st_ff;
      px_in = px_ff; py_in = py_ff; rsp_full_in = rsp_full_ff;
      rd_addr = idx_ff[IB-1:0]; wr_addr = idx_ff[IB-1:0]; wr_en = 1'b0;
      wr_data = a_ff;
      if (rsp_full_ff && rsp_tready) rsp_full_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !rsp_full_ff) begin
               rw_in = req_tdata[DB-1:0];
               rh_in = req_tdata[2*DB-1:DB];
               st_in = grp_pkg::ST_OK; px_in = '0; py_in = '0;
               if (req_tuser[0] == grp_pkg::FUNC_CLEAR) begin
                  // rebuild the single whole-bin entry
                  wr_en = 1'b1; wr_addr = '0;
                  wr_data = '{x: '0, y: '0, w: cw, h: ch};
                  count_in = NB'(1); area_in = '0;
                  state_in = S_OUT;
               end else begin
                  rd_addr = '0; idx_in = '0; rvalid_in = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rvalid_ff && fit) begin
               found_in = idx_ff; c_in = rd_data_ff;
               if (count_ff >= NB'(MAX_FREE)) begin
                  st_in = grp_pkg::ST_FULL; state_in = S_OUT;
               end else begin
                  idx_in = count_ff; state_in = S_SHRD;
               end
            end else if (idx_ff + NB'(1) >= count_ff) begin
               st_in = grp_pkg::ST_MISS; state_in = S_OUT;
            end else begin
               idx_in = idx_ff + NB'(1);
               rd_addr = idx_in[IB-1:0]; rvalid_in = 1'b1;
            end
         end
         S_SHRD: begin
            // idx is the destination slot; move idx-1 up unless at found+1
            if (idx_ff <= found_ff + NB'(1)) begin
               state_in = S_WRA;
            end else begin
               rd_addr = IB'(idx_ff - NB'(1)); state_in = S_SHWR;
            end
            if (dw <= dh) begin
               a_in = '{x: c_ff.x + CB'(rw_ff), y: c_ff.y, w: dw, h: rh_ff};
               b_in = '{x: c_ff.x, y: c_ff.y + CB'(rh_ff), w: c_ff.w, h: dh};
            end else begin
               a_in = '{x: c_ff.x, y: c_ff.y + CB'(rh_ff), w: rw_ff, h: dh};
               b_in = '{x: c_ff.x + CB'(rw_ff), y: c_ff.y, w: dw, h: c_ff.h};
            end
         end
         S_SHWR: begin
            wr_en = 1'b1; wr_data = rd_data_ff;
            idx_in = idx_ff - NB'(1); state_in = S_SHRD;
         end
         S_WRA: begin
            wr_en = 1'b1; wr_addr = found_ff[IB-1:0]; wr_data = a_ff;
            state_in = S_WRB;
         end
         S_WRB: begin
            wr_en = 1'b1; wr_addr = IB'(found_ff + NB'(1)); wr_data = b_ff;
            count_in = count_ff + NB'(1);
            area_in = area_ff + AB'({{DB{1'b0}}, rw_ff} * rh_ff);
            px_in = c_ff.x; py_in = c_ff.y;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_full_ff) begin
               rsp_full_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (reset) begin
         // load the whole reset bin into entry 0
         wr_en = 1'b1; wr_addr = '0;
         wr_data = '{x: '0, y: '0, w: BIN_MAX, h: BIN_MAX};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= NB'(1); area_ff <= '0;
         binw_ff <= DB'(4096); binh_ff <= DB'(4096);
         rsp_full_ff <= 1'b0; rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; area_ff <= area_in;
         rsp_full_ff <= rsp_full_in; rvalid_ff <= rvalid_in;
         if (csr_valid && csr_index == grp_pkg::CSR_BIN_W) binw_ff <= csr_data;
         if (csr_valid && csr_index == grp_pkg::CSR_BIN_H) binh_ff <= csr_data;
      end
      idx_ff <= idx_in; found_ff <= found_in; rw_ff <= rw_in; rh_ff <= rh_in;
      c_ff <= c_in; a_ff <= a_in; b_ff <= b_in; st_ff <= st_in;
      px_ff <= px_in; py_ff <= py_in;
   end

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff >= NB'(1) && count_ff <= NB'(MAX_FREE), "free count out of range")
   `ASSERT_IMPL(a_grow, clock, reset, state_ff == S_WRB |=> count_ff == $past(count_ff) + NB'(1), "count did not grow")
   `ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_full_ff && !rsp_tready |=> rsp_full_ff, "result dropped")
endmodule
`default_nettype wire
